/* design/npcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette color match block.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int SCAN_LEN        = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int IDX_W           = $clog2(SCAN_LEN);
  localparam int CH_W            = 8;
  localparam int SLOT_W          = 8;
  localparam int SUM_W           = CH_W + 1;
  localparam int SQ_W            = 2 * CH_W;
  localparam int WT_W            = 11;
  localparam int PROD_W          = WT_W + SQ_W;
  localparam int DIST_W          = 29;

  localparam logic [WT_W-1:0] RED_WT_BASE  = WT_W'(1024);
  localparam logic [WT_W-1:0] BLUE_WT_BASE = WT_W'(1534);
  localparam int              GREEN_SHIFT  = 11;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

  typedef struct packed {
    scan_tag_t         tag;
    logic [DIST_W-1:0] distance;
  } dist_res_t;

endpackage
`default_nettype wire

/* design/npcm_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_if
// Valid/ready channels for palette requests and match results.
// ----------------------------------------------------------------------------
interface npcm_req_if
  import npcm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;

  modport source (output valid, req_type, slot, red, green, blue, input ready);
  modport sink   (input valid, req_type, slot, red, green, blue, output ready);
endinterface

interface npcm_res_if
  import npcm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] query_slot;
  logic [7:0]        best_index;

  modport source (output valid, query_slot, best_index, input ready);
  modport sink   (input valid, query_slot, best_index, output ready);
endinterface
`default_nettype wire

/* design/npcm_palette_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_palette_ram
// Palette storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module npcm_palette_ram
  import npcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire rgb_t              wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output rgb_t                   rd_data
);

  rgb_t mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/npcm_dist.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_dist
// Pipelined redmean distance between the query color and one palette entry.
// ----------------------------------------------------------------------------
module npcm_dist
  import npcm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire scan_tag_t issue_tag,
  input  wire rgb_t      query,
  input  wire rgb_t      entry,
  output dist_res_t      res
);

  scan_tag_t         t0_r, t1_r, t2_r, t3_r, t4_r;
  logic [SUM_W-1:0]  s1_r;
  logic [CH_W-1:0]   dr1_r, dg1_r, db1_r;
  logic [SQ_W-1:0]   dr2_r, dg2_r, db2_r;
  logic [WT_W-1:0]   wr2_r, wb2_r;
  logic [PROD_W-1:0] pr3_r, pg3_r, pb3_r;
  logic [DIST_W-1:0] d4_r;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // tag pipeline, ram read latency first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r <= '0;
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
    end else begin
      t0_r <= issue_tag;
      t1_r <= t0_r;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= SUM_W'(query.red) + SUM_W'(entry.red);
    dr1_r <= abs_diff(query.red, entry.red);
    dg1_r <= abs_diff(query.green, entry.green);
    db1_r <= abs_diff(query.blue, entry.blue);

    dr2_r <= SQ_W'(dr1_r) * SQ_W'(dr1_r);
    dg2_r <= SQ_W'(dg1_r) * SQ_W'(dg1_r);
    db2_r <= SQ_W'(db1_r) * SQ_W'(db1_r);
    wr2_r <= RED_WT_BASE + WT_W'(s1_r);
    wb2_r <= BLUE_WT_BASE - WT_W'(s1_r);

    pr3_r <= PROD_W'(wr2_r) * PROD_W'(dr2_r);
    pg3_r <= PROD_W'(dg2_r) << GREEN_SHIFT;
    pb3_r <= PROD_W'(wb2_r) * PROD_W'(db2_r);

    d4_r  <= DIST_W'(pr3_r) + DIST_W'(pg3_r) + DIST_W'(pb3_r);
  end

  assign res.tag      = t4_r;
  assign res.distance = d4_r;

endmodule
`default_nettype wire

/* design/npcm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_ctrl
// Request sequencer: palette writes, scan address generation, running
// minimum and the result register.
// ----------------------------------------------------------------------------
module npcm_ctrl
  import npcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire rgb_t              in_color,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SLOT_W-1:0]      out_query_slot,
  output logic [7:0]             out_best_index,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output rgb_t                   wr_data,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  output scan_tag_t              issue_tag,
  output rgb_t                   query,
  input  wire dist_res_t         dres
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0] qslot_r, qslot_nxt;
  rgb_t              qcolor_r, qcolor_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [IDX_W-1:0]  out_best_r, out_best_nxt;

  logic accept;
  logic black_zero;
  logic take_min;
  logic last_idx;
  logic out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign black_zero = (in_slot == '0) && (in_color == '0);
  assign last_idx   = (idx_r == IDX_W'(SCAN_LEN - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign take_min   = dres.tag.valid && ((dres.tag.idx == '0) || (dres.distance < best_d_r));

  // palette write straight from the input transfer
  assign wr_en   = accept && (in_req_type == REQ_WRITE) && (int'(in_slot) < PALETTE_ENTRIES);
  assign wr_addr = ADDR_W'(in_slot);
  assign wr_data = in_color;

  assign rd_en           = (state_r == ST_SCAN);
  assign rd_addr         = ADDR_W'(idx_r);
  assign issue_tag.valid = (state_r == ST_SCAN);
  assign issue_tag.last  = last_idx;
  assign issue_tag.idx   = idx_r;
  assign query           = qcolor_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    qslot_nxt     = qslot_r;
    qcolor_nxt    = qcolor_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_slot_nxt  = out_slot_r;
    out_best_nxt  = out_best_r;

    // running minimum, first minimum wins
    if (take_min) begin
      best_idx_nxt = dres.tag.idx;
      best_d_nxt   = dres.distance;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_QUERY)) begin
          qslot_nxt  = in_slot;
          qcolor_nxt = in_color;
          idx_nxt    = '0;
          if (black_zero) begin
            best_idx_nxt = '0;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dres.tag.valid && dres.tag.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = qslot_r;
          out_best_nxt  = best_idx_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    qslot_r    <= qslot_nxt;
    qcolor_r   <= qcolor_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    out_slot_r <= out_slot_nxt;
    out_best_r <= out_best_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_query_slot = out_slot_r;
  assign out_best_index = 8'(out_best_r);

endmodule
`default_nettype wire

/* design/nearest_palette_color_match.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Holds an RGB palette and returns the entry nearest to a query color under
// the redmean-weighted distance.
// ----------------------------------------------------------------------------
// A write request stores one palette entry; it produces no result. A query
// scans the palette from entry 0 upward through the single read port of the
// palette memory, one entry per cycle, and then drains the palette read
// register and the distance pipeline. The result register is loaded once the
// last distance has reached the running minimum, and the block takes the next
// request from then on; the lowest index wins among equal distances. A query
// for slot 0 with color black skips the scan and returns index 0.
// New requests are taken while the previous result still waits in the output
// register; a finished query waits until that register is free.
// Every entry a query can reach must be written before the first query.
module nearest_palette_color_match
  import npcm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  npcm_req_if.sink    in_req,
  npcm_res_if.source  out_res
);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rgb_t              wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  rgb_t              rd_data;
  scan_tag_t         issue_tag;
  rgb_t              query;
  dist_res_t         dres;
  rgb_t              in_color;

  assign in_color.red   = in_req.red;
  assign in_color.green = in_req.green;
  assign in_color.blue  = in_req.blue;

  npcm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_req.valid),
    .in_ready       (in_req.ready),
    .in_req_type    (in_req.req_type),
    .in_slot        (in_req.slot),
    .in_color       (in_color),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_query_slot (out_res.query_slot),
    .out_best_index (out_res.best_index),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .issue_tag      (issue_tag),
    .query          (query),
    .dres           (dres)
  );

  npcm_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npcm_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_tag (issue_tag),
    .query     (query),
    .entry     (rd_data),
    .res       (dres)
  );

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest palette color match block.
// ----------------------------------------------------------------------------
// Fills the whole palette first. It then runs a short directed set: ties on
// duplicate colors, pure primaries, white, and the black query on slot zero,
// with and without the shortcut. After that comes a long random mix of
// palette writes and queries. A scoreboard keeps its own copy of the palette
// and works out the expected match for every query. Both sides of the block
// idle at random, and the result side stalls twice for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import npcm_pkg::*;

  localparam int          CLK_HALF      = 6;
  localparam int          RANDOM_ITEMS  = 1275;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          TAIL_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          RED_BASE      = 1024;
  localparam int          BLUE_BASE     = 1534;
  localparam int          GREEN_WEIGHT  = 2048;
  localparam bit [7:0]    CORNER_LEVELS [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

  typedef struct packed {
    logic [SLOT_W-1:0] query_slot;
    logic [7:0]        best_index;
  } match_t;

  class match_predictor;
    rgb_t        palette [PALETTE_ENTRIES];
    match_t      pending_matches [$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function int unsigned redmean_dist(rgb_t q, rgb_t e);
      int s, dr, dg, db;
      s  = int'(q.red) + int'(e.red);
      dr = int'(q.red) - int'(e.red);
      dg = int'(q.green) - int'(e.green);
      db = int'(q.blue) - int'(e.blue);
      return (RED_BASE + s) * dr * dr + GREEN_WEIGHT * dg * dg + (BLUE_BASE - s) * db * db;
    endfunction

    function void flag();
      failures++;
    endfunction

    function void note_request(logic kind, logic [SLOT_W-1:0] slot, rgb_t color);
      match_t      m;
      int          best;
      int unsigned best_d, d;
      if (kind == REQ_WRITE) begin
        if (slot < PALETTE_ENTRIES) palette[slot] = color;
        return;
      end
      best   = 0;
      best_d = 0;
      // black on slot zero skips the scan
      if (!(slot == '0 && color == '0)) begin
        for (int i = 0; i < SCAN_LEN; i++) begin
          d = redmean_dist(color, palette[i]);
          if (i == 0 || d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
      end
      m.query_slot = slot;
      m.best_index = 8'(best);
      pending_matches.push_back(m);
    endfunction

    function void check_match(logic [SLOT_W-1:0] slot, logic [7:0] index);
      match_t m;
      if (pending_matches.size() == 0) begin
        if (failures < 10)
          $display("unexpected transfer: slot %0d index %0d", slot, index);
        flag();
        return;
      end
      m = pending_matches.pop_front();
      if (slot !== m.query_slot || index !== m.best_index) begin
        if (failures < 10)
          $display("mismatch: expected slot %0d index %0d, got slot %0d index %0d",
                   m.query_slot, m.best_index, slot, index);
        flag();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int          items_sent;
  int          matches_seen;
  int unsigned cycle_count;

  npcm_req_if req_bus ();
  npcm_res_if res_bus ();

  match_predictor predictor = new();

  nearest_palette_color_match i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_res (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // bursts of 50 transfers with no idling in every 200
  function automatic int draw_idle(int n);
    if (n % 200 >= 150) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic rgb_t pick_color();
    rgb_t c;
    if ($urandom_range(0, 99) < 30) begin
      c.red   = CORNER_LEVELS[$urandom_range(0, 5)];
      c.green = CORNER_LEVELS[$urandom_range(0, 5)];
      c.blue  = CORNER_LEVELS[$urandom_range(0, 5)];
    end else begin
      c = 24'($urandom);
    end
    return c;
  endfunction

  task automatic send_request(logic kind, logic [SLOT_W-1:0] slot, rgb_t color);
    int gap;
    gap = draw_idle(items_sent);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.slot     <= slot;
    req_bus.red      <= color.red;
    req_bus.green    <= color.green;
    req_bus.blue     <= color.blue;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predictor.note_request(kind, slot, color);
    items_sent++;
  endtask

  // result side
  initial begin
    int stall;
    matches_seen = 0;
    res_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_idle(matches_seen);
      if (matches_seen == 25 || matches_seen == 250) stall = HOLD_CYCLES;
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
      predictor.check_match(res_bus.query_slot, res_bus.best_index);
      matches_seen++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL nearest_palette_color_match");
    $finish;
  end

  initial begin
    int   dice;
    rgb_t color;
    items_sent = 0;
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_WRITE;
    req_bus.slot     <= '0;
    req_bus.red      <= '0;
    req_bus.green    <= '0;
    req_bus.blue     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // every entry a scan reaches is written before the first query
    for (int i = 0; i < PALETTE_ENTRIES; i++)
      send_request(REQ_WRITE, SLOT_W'(i), pick_color());

    send_request(REQ_WRITE, 8'd17,  24'hFFFFFF);
    send_request(REQ_WRITE, 8'd255, 24'hFFFFFF);
    send_request(REQ_WRITE, 8'd128, 24'hFF0000);
    send_request(REQ_WRITE, 8'd129, 24'h00FF00);
    send_request(REQ_WRITE, 8'd130, 24'h0000FF);
    send_request(REQ_WRITE, 8'd0,   24'h0A141E);
    send_request(REQ_QUERY, 8'd0,   24'h000000);
    send_request(REQ_QUERY, 8'd1,   24'h000000);
    send_request(REQ_QUERY, 8'd0,   24'h000001);
    send_request(REQ_QUERY, 8'd255, 24'hFF0000);
    send_request(REQ_QUERY, 8'd128, 24'h00FF00);
    send_request(REQ_QUERY, 8'd200, 24'h0000FF);
    send_request(REQ_QUERY, 8'd5,   24'hFFFFFF);
    send_request(REQ_QUERY, 8'd0,   24'hFFFFFF);
    send_request(REQ_QUERY, 8'd77,  24'h0A141E);
    send_request(REQ_QUERY, 8'd3,   24'hFF00FF);
    send_request(REQ_WRITE, 8'd0,   24'h000000);
    send_request(REQ_QUERY, 8'd9,   24'h000000);
    send_request(REQ_QUERY, 8'd0,   24'h000000);
    send_request(REQ_QUERY, 8'd254, 24'h808080);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        send_request(REQ_WRITE, SLOT_W'($urandom_range(0, 255)), pick_color());
      end else begin
        dice = $urandom_range(0, 99);
        if (dice < 10) begin
          send_request(REQ_QUERY, '0, '0);
        end else if (dice < 40) begin
          color = predictor.palette[$urandom_range(0, PALETTE_ENTRIES - 1)];
          send_request(REQ_QUERY, SLOT_W'($urandom_range(0, 255)), color);
        end else begin
          send_request(REQ_QUERY, SLOT_W'($urandom_range(0, 255)), pick_color());
        end
      end
    end
    req_bus.valid <= 1'b0;

    while (predictor.pending_matches.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (predictor.failures == 0) begin
      $display("PASS nearest_palette_color_match");
    end else begin
      $display("FAIL nearest_palette_color_match");
    end
    $finish;
  end

endmodule

/* nearest_palette_color_match.f */
design/npcm_pkg.sv
design/npcm_if.sv
design/npcm_palette_ram.sv
design/npcm_dist.sv
design/npcm_ctrl.sv
design/nearest_palette_color_match.sv
verif/tb.sv
